FILE: rtl/core/assert_macros.svh
// Assertion macros for the checker file of the parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is high.
`define DTFP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("dtfp check failed");

// Concurrent check that also holds through reset.
`define DTFP_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("dtfp check failed");

`endif

FILE: rtl/core/dtfp_pkg.sv
// Package: types, character codes, phase codes and microcode program of the parser.
`timescale 1ns / 1ps

package dtfp_pkg;

   // Fixed field widths
   localparam int CHAR_BITS   = 8;
   localparam int FRAC_BITS   = 30;
   localparam int FCNT_BITS   = 4;
   localparam int QUO_BITS    = 32;
   localparam int QCNT_BITS   = 5;
   localparam int STEP_BITS   = 3;
   localparam int COND_BITS   = 3;
   localparam int PHASE_BITS  = 3;
   localparam int INT_OUT_BITS = 32;
   localparam int OFF_OUT_BITS = 16;

   // Character codes
   localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_BITS-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_BITS-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CHAR_POINT = 8'h2E;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 8'h39;

   // Scan phases
   localparam logic [PHASE_BITS-1:0] PH_DONE = 3'd0;
   localparam logic [PHASE_BITS-1:0] PH_LEAD = 3'd1;
   localparam logic [PHASE_BITS-1:0] PH_PLUS = 3'd2;
   localparam logic [PHASE_BITS-1:0] PH_INT  = 3'd3;
   localparam logic [PHASE_BITS-1:0] PH_FRAC = 3'd4;

   // Jump conditions
   localparam logic [COND_BITS-1:0] COND_NONE     = 3'd0;
   localparam logic [COND_BITS-1:0] COND_NO_INPUT = 3'd1;
   localparam logic [COND_BITS-1:0] COND_ENDS     = 3'd2;
   localparam logic [COND_BITS-1:0] COND_DIV_MORE = 3'd3;
   localparam logic [COND_BITS-1:0] COND_OUT_BUSY = 3'd4;

   // Program steps
   localparam logic [STEP_BITS-1:0] STEP_FETCH    = 3'd0;
   localparam logic [STEP_BITS-1:0] STEP_EXEC     = 3'd1;
   localparam logic [STEP_BITS-1:0] STEP_DIV_INIT = 3'd2;
   localparam logic [STEP_BITS-1:0] STEP_DIV_STEP = 3'd3;
   localparam logic [STEP_BITS-1:0] STEP_OUT      = 3'd4;

   // One control word
   typedef struct packed {
      logic                 accept;
      logic                 exec;
      logic                 div_init;
      logic                 div_step;
      logic                 out_load;
      logic [COND_BITS-1:0] cond;
      logic [STEP_BITS-1:0] jump_step;
      logic [STEP_BITS-1:0] next_step;
   } ucode_type;

   // Microcode program: jump_step when the condition holds, else next_step
   function automatic ucode_type ucode_rom(input logic [STEP_BITS-1:0] step);
      ucode_type uc;
      uc = '0;
      case (step)
         STEP_FETCH: begin
            uc.accept    = 1'b1;
            uc.cond      = COND_NO_INPUT;
            uc.jump_step = STEP_FETCH;
            uc.next_step = STEP_EXEC;
         end
         STEP_EXEC: begin
            uc.exec      = 1'b1;
            uc.cond      = COND_ENDS;
            uc.jump_step = STEP_DIV_INIT;
            uc.next_step = STEP_FETCH;
         end
         STEP_DIV_INIT: begin
            uc.div_init  = 1'b1;
            uc.cond      = COND_NONE;
            uc.jump_step = STEP_DIV_STEP;
            uc.next_step = STEP_DIV_STEP;
         end
         STEP_DIV_STEP: begin
            uc.div_step  = 1'b1;
            uc.cond      = COND_DIV_MORE;
            uc.jump_step = STEP_DIV_STEP;
            uc.next_step = STEP_OUT;
         end
         STEP_OUT: begin
            uc.out_load  = 1'b1;
            uc.cond      = COND_OUT_BUSY;
            uc.jump_step = STEP_OUT;
            uc.next_step = STEP_FETCH;
         end
         default: begin
            uc.cond      = COND_NONE;
            uc.jump_step = STEP_FETCH;
            uc.next_step = STEP_FETCH;
         end
      endcase
      return uc;
   endfunction

   // Divisor 10^k for k kept fraction digits
   function automatic logic [FRAC_BITS-1:0] pow_ten(input logic [FCNT_BITS-1:0] k);
      logic [FRAC_BITS-1:0] p;
      case (k)
         4'd0:    p = 30'd1;
         4'd1:    p = 30'd10;
         4'd2:    p = 30'd100;
         4'd3:    p = 30'd1000;
         4'd4:    p = 30'd10000;
         4'd5:    p = 30'd100000;
         4'd6:    p = 30'd1000000;
         4'd7:    p = 30'd10000000;
         4'd8:    p = 30'd100000000;
         4'd9:    p = 30'd1000000000;
         default: p = 30'd1;
      endcase
      return p;
   endfunction

endpackage

FILE: rtl/core/dtfp_if.sv
// Interfaces: character request channel and number response channel.
`timescale 1ns / 1ps

interface dtfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       string_start;

   modport source  (output valid, output char_code, output string_start, input ready);
   modport sink    (input valid, input char_code, input string_start, output ready);
   modport monitor (input valid, input char_code, input string_start, input ready);
endinterface

interface dtfp_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_negative;
   logic [31:0] int_part;
   logic [31:0] frac_part;
   logic [15:0] stop_offset;
   logic        empty_string;
   logic        overflow;

   modport source  (output valid, output is_negative, output int_part, output frac_part,
                    output stop_offset, output empty_string, output overflow, input ready);
   modport sink    (input valid, input is_negative, input int_part, input frac_part,
                    input stop_offset, input empty_string, input overflow, output ready);
   modport monitor (input valid, input is_negative, input int_part, input frac_part,
                    input stop_offset, input empty_string, input overflow, input ready);
endinterface

FILE: rtl/core/decimal_text_to_fixed_parser.sv
// Top level: microcoded parser from ASCII decimal text to a fixed-point number.
//
//   channel  | direction | word
//   ---------+-----------+-------------------------------------------------------
//   req_port | in        | char_code, string_start
//   rsp_port | out       | is_negative, int_part, frac_part, stop_offset,
//            |           | empty_string, overflow
//
// Each character passes through a fetch step and an execute step of the program.
// The word that ends a number adds a divider init step, divide steps and an output step:
// the fraction is divided by 10^k in a restoring divider, one quotient bit per cycle.
// The result sits in an output register; the next character is taken while it waits,
// and a later result stalls in the output step until the register is free.
// Reset (synchronous) returns the program to the fetch step with no string open.
`timescale 1ns / 1ps

module decimal_text_to_fixed_parser
   import dtfp_pkg::*;
#(
   parameter int FRAC_DIGITS = 9,
   parameter int INT_BITS    = 32,
   parameter int OFFSET_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   dtfp_req_if.sink    req_port,
   dtfp_rsp_if.source  rsp_port
);

   localparam logic [INT_BITS-1:0]    INT_MAX = '1;
   localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;
   localparam logic [FCNT_BITS-1:0]   FRAC_LIMIT = FCNT_BITS'(FRAC_DIGITS);

   // Sequencer
   logic [STEP_BITS-1:0] step_ff, step_in;
   ucode_type            uc;
   logic                 cond_true;

   // Latched character
   logic [CHAR_BITS-1:0] char_ff;
   logic                 start_ff;

   // Number state
   logic [PHASE_BITS-1:0]  phase_ff, phase_in;
   logic                   neg_ff, neg_in;
   logic [INT_BITS-1:0]    int_ff, int_in;
   logic                   sat_ff, sat_in;
   logic [FRAC_BITS-1:0]   frac_ff, frac_in;
   logic [FCNT_BITS-1:0]   fcnt_ff, fcnt_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic                   empty_ff, empty_in;

   // Execute step signals
   logic [PHASE_BITS-1:0]  phase_cur;
   logic                   neg_cur, sat_cur;
   logic [INT_BITS-1:0]    int_cur;
   logic [FRAC_BITS-1:0]   frac_cur;
   logic [FCNT_BITS-1:0]   fcnt_cur;
   logic [OFFSET_BITS-1:0] pos_cur;
   logic                   is_digit, is_blank, ends, advance;
   logic [3:0]             digit;
   logic [INT_BITS+3:0]    int_prod;
   logic [FRAC_BITS+3:0]   frac_prod;

   // Divider
   logic [FRAC_BITS-1:0] rem_ff, div_ff;
   logic [QUO_BITS-1:0]  quo_ff;
   logic [QCNT_BITS-1:0] qcnt_ff;
   logic [FRAC_BITS:0]   rem_shift;
   logic                 rem_ge;

   // Output register
   logic                    rsp_valid_ff;
   logic                    out_busy, out_fire;
   logic                    rsp_neg_ff, rsp_empty_ff, rsp_ovf_ff;
   logic [INT_OUT_BITS-1:0] rsp_int_ff;
   logic [QUO_BITS-1:0]     rsp_frac_ff;
   logic [OFF_OUT_BITS-1:0] rsp_off_ff;
   logic [INT_BITS+INT_OUT_BITS-1:0]    int_ext;
   logic [OFFSET_BITS+OFF_OUT_BITS-1:0] pos_ext;

   // Decode the current control word and pick the next step
   assign uc       = ucode_rom(step_ff);
   assign out_busy = rsp_valid_ff && !rsp_port.ready;
   assign out_fire = uc.out_load && !out_busy;

   always_comb begin
      case (uc.cond)
         COND_NONE:     cond_true = 1'b0;
         COND_NO_INPUT: cond_true = !req_port.valid;
         COND_ENDS:     cond_true = ends;
         COND_DIV_MORE: cond_true = (qcnt_ff != '0);
         COND_OUT_BUSY: cond_true = out_busy;
         default:       cond_true = 1'b0;
      endcase
      step_in = cond_true ? uc.jump_step : uc.next_step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_FETCH;
      end else begin
         step_ff <= step_in;
      end
   end

   assign req_port.ready = uc.accept;

   // Latch the character word on accept
   always_ff @(posedge clock) begin
      if (req_port.valid && req_port.ready) begin
         char_ff  <= req_port.char_code;
         start_ff <= req_port.string_start;
      end
   end

   // Classify and apply the character; a string start clears the number first
   always_comb begin
      phase_cur = start_ff ? PH_LEAD : phase_ff;
      neg_cur   = start_ff ? 1'b0 : neg_ff;
      int_cur   = start_ff ? '0 : int_ff;
      sat_cur   = start_ff ? 1'b0 : sat_ff;
      frac_cur  = start_ff ? '0 : frac_ff;
      fcnt_cur  = start_ff ? '0 : fcnt_ff;
      pos_cur   = start_ff ? '0 : pos_ff;

      is_digit  = (char_ff >= CHAR_ZERO) && (char_ff <= CHAR_NINE);
      is_blank  = (char_ff == CHAR_SPACE) || (char_ff == CHAR_TAB);
      digit     = char_ff[3:0];
      int_prod  = ({4'b0000, int_cur} << 3) + ({4'b0000, int_cur} << 1)
                  + (INT_BITS+4)'(digit);
      frac_prod = ({4'b0000, frac_cur} << 3) + ({4'b0000, frac_cur} << 1)
                  + (FRAC_BITS+4)'(digit);

      phase_in = phase_cur;
      neg_in   = neg_cur;
      int_in   = int_cur;
      sat_in   = sat_cur;
      frac_in  = frac_cur;
      fcnt_in  = fcnt_cur;
      empty_in = 1'b0;
      ends     = 1'b0;
      advance  = 1'b0;

      case (phase_cur)
         PH_LEAD, PH_PLUS: begin
            if (phase_cur == PH_LEAD && is_blank) begin
               advance = 1'b1;
            end else if (phase_cur == PH_LEAD && char_ff == CHAR_PLUS) begin
               phase_in = PH_PLUS;
               advance  = 1'b1;
            end else if (char_ff == CHAR_NUL) begin
               ends     = 1'b1;
               empty_in = 1'b1;
            end else if (char_ff == CHAR_MINUS) begin
               neg_in   = 1'b1;
               phase_in = PH_INT;
               advance  = 1'b1;
            end else if (is_digit) begin
               phase_in = PH_INT;
               advance  = 1'b1;
               if (int_prod[INT_BITS+3:INT_BITS] != 4'b0000) begin
                  int_in = INT_MAX;
                  sat_in = 1'b1;
               end else begin
                  int_in = int_prod[INT_BITS-1:0];
               end
            end else if (char_ff == CHAR_POINT) begin
               phase_in = PH_FRAC;
               advance  = 1'b1;
            end else begin
               ends = 1'b1;
            end
         end
         PH_INT: begin
            if (is_digit) begin
               advance = 1'b1;
               if (!sat_cur) begin
                  if (int_prod[INT_BITS+3:INT_BITS] != 4'b0000) begin
                     int_in = INT_MAX;
                     sat_in = 1'b1;
                  end else begin
                     int_in = int_prod[INT_BITS-1:0];
                  end
               end
            end else if (char_ff == CHAR_POINT) begin
               phase_in = PH_FRAC;
               advance  = 1'b1;
            end else begin
               ends = 1'b1;
            end
         end
         PH_FRAC: begin
            if (is_digit) begin
               advance = 1'b1;
               // drop digits past the kept precision
               if (fcnt_cur < FRAC_LIMIT) begin
                  frac_in = frac_prod[FRAC_BITS-1:0];
                  fcnt_in = fcnt_cur + 1'b1;
               end
            end else begin
               ends = 1'b1;
            end
         end
         default: begin
            // no open string: ignore the word
         end
      endcase

      if (ends) begin
         phase_in = PH_DONE;
      end
      pos_in = (advance && pos_cur != POS_MAX) ? pos_cur + 1'b1 : pos_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DONE;
         neg_ff   <= 1'b0;
         int_ff   <= '0;
         sat_ff   <= 1'b0;
         frac_ff  <= '0;
         fcnt_ff  <= '0;
         pos_ff   <= '0;
         empty_ff <= 1'b0;
      end else if (uc.exec) begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         int_ff   <= int_in;
         sat_ff   <= sat_in;
         frac_ff  <= frac_in;
         fcnt_ff  <= fcnt_in;
         pos_ff   <= pos_in;
         empty_ff <= empty_in;
      end
   end

   // Restoring divider: (frac << 32) / 10^k, one quotient bit per step
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = (rem_shift >= {1'b0, div_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         qcnt_ff <= '0;
      end else if (uc.div_init) begin
         qcnt_ff <= QCNT_BITS'(QUO_BITS - 1);
      end else if (uc.div_step && qcnt_ff != '0) begin
         qcnt_ff <= qcnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (uc.div_init) begin
         rem_ff <= frac_ff;
         div_ff <= pow_ten(fcnt_ff);
         quo_ff <= '0;
      end else if (uc.div_step) begin
         rem_ff <= rem_ge ? FRAC_BITS'(rem_shift - {1'b0, div_ff})
                          : rem_shift[FRAC_BITS-1:0];
         quo_ff <= {quo_ff[QUO_BITS-2:0], rem_ge};
      end
   end

   // Load the result word; an empty string reports zeros
   assign int_ext = {{INT_OUT_BITS{1'b0}}, int_ff};
   assign pos_ext = {{OFF_OUT_BITS{1'b0}}, pos_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_fire) begin
         rsp_neg_ff   <= !empty_ff && neg_ff;
         rsp_int_ff   <= empty_ff ? '0 : int_ext[INT_OUT_BITS-1:0];
         rsp_frac_ff  <= empty_ff ? '0 : quo_ff;
         rsp_off_ff   <= empty_ff ? '0 : pos_ext[OFF_OUT_BITS-1:0];
         rsp_empty_ff <= empty_ff;
         rsp_ovf_ff   <= !empty_ff && sat_ff;
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.is_negative  = rsp_neg_ff;
   assign rsp_port.int_part     = rsp_int_ff;
   assign rsp_port.frac_part    = rsp_frac_ff;
   assign rsp_port.stop_offset  = rsp_off_ff;
   assign rsp_port.empty_string = rsp_empty_ff;
   assign rsp_port.overflow     = rsp_ovf_ff;

endmodule

FILE: rtl/core/dtfp_checker.sv
// Checker on the parser's ports, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtfp_checker (
   input logic          clock,
   input logic          reset,
   dtfp_req_if.sink     req_port,
   dtfp_rsp_if.source   rsp_port
);

   // Result register comes out of reset empty
   `DTFP_ASSERT_ALWAYS(a_rsp_idle_after_reset, clock, $past(reset) |-> !rsp_port.valid)

   // A waiting result word holds until taken
   `DTFP_ASSERT(a_rsp_hold, clock, reset, rsp_port.valid && !rsp_port.ready |=> rsp_port.valid && $stable(rsp_port.int_part) && $stable(rsp_port.frac_part) && $stable(rsp_port.stop_offset))

   // An empty string reports nothing else
   `DTFP_ASSERT(a_empty_zero, clock, reset, rsp_port.valid && rsp_port.empty_string |-> !rsp_port.is_negative && rsp_port.int_part == 32'd0 && rsp_port.frac_part == 32'd0 && rsp_port.stop_offset == 16'd0 && !rsp_port.overflow)

   // Overflow means the integer part is saturated; only its low byte is checked
   `DTFP_ASSERT(a_overflow_sat, clock, reset, rsp_port.valid && rsp_port.overflow |-> rsp_port.int_part[7:0] == 8'hFF)

   // A new result never appears right after a character word was taken
   `DTFP_ASSERT(a_rsp_after_divide, clock, reset, $rose(rsp_port.valid) |-> !$past(req_port.valid && req_port.ready))

endmodule

bind decimal_text_to_fixed_parser dtfp_checker u_dtfp_checker (
   .clock    (clock),
   .reset    (reset),
   .req_port (req_port),
   .rsp_port (rsp_port)
);

FILE: tb/decimal_text_to_fixed_parser_checker.sv
// Checker for the decimal text parser: predicts each number and compares it field by field.
`timescale 1ns / 1ps

module decimal_text_to_fixed_parser_checker
   import dtfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   dtfp_req_if.monitor req_mon,
   dtfp_rsp_if.monitor rsp_mon,
   output int          fail_count,
   output int          pending_count,
   output int          number_count,
   output int          empty_count,
   output int          overflow_count
);

   localparam int              FRAC_LIMIT   = 9;
   localparam longint unsigned INT_LIMIT    = 64'hFFFF_FFFF;
   localparam logic [15:0]     OFFSET_LIMIT = 16'hFFFF;

   typedef struct packed {
      logic        is_negative;
      logic [31:0] int_part;
      logic [31:0] frac_part;
      logic [15:0] stop_offset;
      logic        empty_string;
      logic        overflow;
   } number_type;

   // Scan state of the string being parsed
   logic [PHASE_BITS-1:0] scan_phase;
   bit                    minus_taken;
   longint unsigned       int_value;
   longint unsigned       frac_value;
   int                    frac_digits;
   logic [15:0]           char_index;
   bit                    int_clipped;

   number_type expected_numbers[$];
   int      errors    = 0;
   int      compared  = 0;
   int      empties   = 0;
   int      clipped   = 0;

   function automatic void clear_number();
      minus_taken = 1'b0;
      int_value   = 0;
      frac_value  = 0;
      frac_digits = 0;
      char_index  = '0;
      int_clipped = 1'b0;
   endfunction

   // Accumulate one integer digit; hold at the limit once clipped
   function automatic void add_int_digit(input longint unsigned d);
      if (!int_clipped) begin
         if (int_value > (INT_LIMIT - d) / 10) begin
            int_value   = INT_LIMIT;
            int_clipped = 1'b1;
         end else begin
            int_value = int_value * 10 + d;
         end
      end
   endfunction

   // Close the string: build the number and drop back to waiting for a start
   function automatic number_type finish_number(input bit empty);
      number_type      num;
      longint unsigned divisor;
      longint unsigned quotient;
      quotient = 0;
      if (!empty && frac_digits > 0) begin
         divisor = 1;
         repeat (frac_digits) divisor = divisor * 10;
         quotient = (frac_value << 32) / divisor;
      end
      num.is_negative  = empty ? 1'b0 : minus_taken;
      num.int_part     = empty ? 32'd0 : int_value[31:0];
      num.frac_part    = quotient[31:0];
      num.stop_offset  = empty ? 16'd0 : char_index;
      num.empty_string = empty;
      num.overflow     = empty ? 1'b0 : int_clipped;
      scan_phase       = PH_DONE;
      return num;
   endfunction

   // Advance the scan by one character; return 1 when it ends a number
   function automatic bit scan_char(input logic [7:0] c, input logic first,
                                    output number_type num);
      bit              is_digit;
      longint unsigned d;
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      d        = c[3:0];
      num      = '0;
      if (first) begin
         clear_number();
         scan_phase = PH_LEAD;
      end
      if (scan_phase == PH_DONE) return 1'b0;
      case (scan_phase)
         PH_LEAD, PH_PLUS: begin
            if (scan_phase == PH_LEAD && (c == CHAR_SPACE || c == CHAR_TAB)) begin
               // blanks only before the sign
            end else if (scan_phase == PH_LEAD && c == CHAR_PLUS) begin
               scan_phase = PH_PLUS;
            end else if (c == CHAR_NUL) begin
               num = finish_number(1'b1);
               return 1'b1;
            end else if (c == CHAR_MINUS) begin
               minus_taken = 1'b1;
               scan_phase  = PH_INT;
            end else if (is_digit) begin
               add_int_digit(d);
               scan_phase = PH_INT;
            end else if (c == CHAR_POINT) begin
               scan_phase = PH_FRAC;
            end else begin
               num = finish_number(1'b0);
               return 1'b1;
            end
         end
         PH_INT: begin
            if (is_digit) begin
               add_int_digit(d);
            end else if (c == CHAR_POINT) begin
               scan_phase = PH_FRAC;
            end else begin
               num = finish_number(1'b0);
               return 1'b1;
            end
         end
         default: begin
            if (!is_digit) begin
               num = finish_number(1'b0);
               return 1'b1;
            end
            // extra digits are consumed without effect
            if (frac_digits < FRAC_LIMIT) begin
               frac_value = frac_value * 10 + d;
               frac_digits++;
            end
         end
      endcase
      if (char_index != OFFSET_LIMIT) char_index++;
      return 1'b0;
   endfunction

   function automatic void check_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // Compare result words first, then predict from the accepted character word
   always @(posedge clock) begin
      number_type predicted;
      number_type seen;
      bit         made;
      if (reset) begin
         scan_phase = PH_DONE;
         clear_number();
         expected_numbers.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.is_negative  = rsp_mon.is_negative;
            seen.int_part     = rsp_mon.int_part;
            seen.frac_part    = rsp_mon.frac_part;
            seen.stop_offset  = rsp_mon.stop_offset;
            seen.empty_string = rsp_mon.empty_string;
            seen.overflow     = rsp_mon.overflow;
            if (expected_numbers.size() == 0) begin
               $display("%0t ns: unexpected result word, expected none, actual %h",
                        $time, seen);
               errors++;
            end else begin
               predicted = expected_numbers.pop_front();
               check_field("is_negative", predicted.is_negative, seen.is_negative);
               check_field("int_part", predicted.int_part, seen.int_part);
               check_field("frac_part", predicted.frac_part, seen.frac_part);
               check_field("stop_offset", predicted.stop_offset, seen.stop_offset);
               check_field("empty_string", predicted.empty_string, seen.empty_string);
               check_field("overflow", predicted.overflow, seen.overflow);
               compared++;
               if (predicted.empty_string) empties++;
               if (predicted.overflow) clipped++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            made = scan_char(req_mon.char_code, req_mon.string_start, predicted);
            if (made) expected_numbers.push_back(predicted);
         end
      end
      fail_count     <= errors;
      pending_count  <= expected_numbers.size();
      number_count   <= compared;
      empty_count    <= empties;
      overflow_count <= clipped;
   end

endmodule

FILE: tb/decimal_text_to_fixed_parser_tb.sv
// Testbench top for the decimal text parser: clock, reset, character stimulus and verdict.
`timescale 1ns / 1ps

module decimal_text_to_fixed_parser_tb;
   import dtfp_pkg::*;

   logic clock;
   logic reset;
   bit   flush_out;

   int fail_count;
   int pending_count;
   int number_count;
   int empty_count;
   int overflow_count;

   int char_count   = 0;
   int word_count   = 0;
   int string_count = 0;
   int gap_max      = 4;
   int burst_left   = 0;

   dtfp_req_if req_chan ();
   dtfp_rsp_if rsp_chan ();

   decimal_text_to_fixed_parser u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_chan),
      .rsp_port (rsp_chan)
   );

   decimal_text_to_fixed_parser_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .number_count   (number_count),
      .empty_count    (empty_count),
      .overflow_count (overflow_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Stall the result side: always ready, coin flips, rare ready, then long level runs
   initial begin
      int hold;
      bit level;
      int cycle;
      hold  = 0;
      level = 1'b0;
      cycle = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cycle++;
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (flush_out) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            case ((cycle / 700) % 4)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= ($urandom_range(0, 1) == 1);
               2: rsp_chan.ready <= ($urandom_range(0, 5) == 0);
               default: begin
                  if (hold == 0) begin
                     level = ~level;
                     hold  = level ? $urandom_range(1, 10) : $urandom_range(1, 40);
                  end
                  hold--;
                  rsp_chan.ready <= level;
               end
            endcase
         end
      end
   end

   // Send one character word; keep valid high inside a burst, drop it for a gap
   task automatic send_char(input logic [7:0] c, input logic first, input bit counted);
      req_chan.valid        <= 1'b1;
      req_chan.char_code    <= c;
      req_chan.string_start <= first;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      word_count++;
      if (counted) char_count++;
      if (gap_max > 0) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
         end
      end
   endtask

   // Send a string; words from junk_at on come after the stop and are ignored
   task automatic send_text(input logic [7:0] text[$], input int junk_at);
      foreach (text[i]) send_char(text[i], i == 0, i < junk_at);
      string_count++;
   endtask

   task automatic send_lit(input string s, input bit with_nul);
      logic [7:0] text[$];
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
      if (with_nul) text.push_back(CHAR_NUL);
      send_text(text, text.size());
   endtask

   // Hold the sender until every predicted number has come out
   task automatic wait_for_numbers();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Build a well-formed number with random content, optionally cut before its stop
   task automatic make_number(output logic [7:0] text[$], output int junk_at,
                              input bit cut_short);
      string near_max;
      int    n;
      int    style;
      near_max = "429496729";
      text     = {};
      style    = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) text.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
      if ($urandom_range(0, 3) == 0) text.push_back(CHAR_PLUS);
      if ($urandom_range(0, 19) == 0) text.push_back(CHAR_SPACE);
      if ($urandom_range(0, 2) == 0) text.push_back(CHAR_MINUS);
      case ($urandom_range(0, 9))
         0:       n = 0;
         1:       n = $urandom_range(10, 12);
         default: n = $urandom_range(1, 5);
      endcase
      if ($urandom_range(0, 39) == 0) begin
         // land right at the saturation boundary
         for (int i = 0; i < near_max.len(); i++) text.push_back(near_max[i]);
         text.push_back(8'(CHAR_ZERO + $urandom_range(4, 6)));
      end else begin
         repeat (n) text.push_back(style == 0 ? CHAR_NINE : style == 1 ? CHAR_ZERO
                                   : 8'(CHAR_ZERO + $urandom_range(0, 9)));
      end
      if ($urandom_range(0, 2) != 0) begin
         text.push_back(CHAR_POINT);
         repeat ($urandom_range(0, 13))
            text.push_back(style == 0 ? CHAR_NINE : style == 1 ? CHAR_ZERO
                           : 8'(CHAR_ZERO + $urandom_range(0, 9)));
      end
      if (cut_short) begin
         if (text.size() == 0) text.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
         junk_at = text.size();
      end else begin
         case ($urandom_range(0, 5))
            0, 1, 2: text.push_back(CHAR_NUL);
            3:       text.push_back(CHAR_SPACE);
            4:       text.push_back(8'($urandom_range(0, 255)));
            default: text.push_back(CHAR_MINUS);
         endcase
         junk_at = text.size();
         repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      logic [7:0] text[$];
      int         junk_at;
      int         pick;
      reset                 <= 1'b1;
      flush_out             <= 1'b0;
      req_chan.valid        <= 1'b0;
      req_chan.char_code    <= CHAR_NUL;
      req_chan.string_start <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Words before any start flag change nothing
      send_char(CHAR_NINE, 1'b0, 1'b0);
      send_char(CHAR_NUL, 1'b0, 1'b0);

      // Directed strings: blanks and plus, empties, lone sign or point, limits
      send_lit(" \t+12.5", 1'b1);
      send_lit("", 1'b1);
      send_lit(" +", 1'b1);
      send_lit("+ 5", 1'b1);
      send_lit("-", 1'b1);
      send_lit(".x", 1'b0);
      send_lit("-.", 1'b1);
      send_lit("4294967295", 1'b1);
      send_lit("4294967296", 1'b1);
      send_lit("-0.1234567891", 1'b1);
      send_lit("-7", 1'b0);
      send_lit("3,9", 1'b0);
      wait_for_numbers();

      // Random part: mostly well-formed numbers, some cut short, some noise
      gap_max = 4;
      while (word_count < 1950) begin
         pick = $urandom_range(0, 19);
         if (pick < 15) begin
            make_number(text, junk_at, 1'b0);
            send_text(text, junk_at);
         end else if (pick < 17) begin
            make_number(text, junk_at, 1'b1);
            send_text(text, junk_at);
         end else begin
            repeat ($urandom_range(1, 6)) begin
               pick = $urandom_range(0, 3);
               send_char(8'($urandom_range(0, 255)), pick == 0, pick == 0);
            end
         end
         if ($urandom_range(0, 49) == 0) gap_max = $urandom_range(0, 6);
         if ($urandom_range(0, 99) == 0) wait_for_numbers();
      end

      // Drain, then give a trailing result time to show up
      wait_for_numbers();
      flush_out <= 1'b1;
      repeat (60) @(posedge clock);

      $display("Sent %0d words in %0d strings, %0d of them inside numbers.",
               word_count, string_count, char_count);
      $display("Compared %0d numbers: %0d empty strings, %0d saturated integers.",
               number_count, empty_count, overflow_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
